// ===== src/atup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atup_pkg
// Shared widths, character codes, parse phases and state type for the
// ASCII to unsigned integer parser.
// ----------------------------------------------------------------------------
package atup_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned RADIX_WIDTH = 6;
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned OUT_TDATA_WIDTH = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_WIDTH-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [CHAR_WIDTH-1:0] CH_LC_X  = 8'h78;

  localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_WIDTH-1:0] BASE_OCT   = 6'd8;
  localparam logic [RADIX_WIDTH-1:0] BASE_DEC   = 6'd10;
  localparam logic [RADIX_WIDTH-1:0] BASE_HEX   = 6'd16;
  localparam logic [RADIX_WIDTH-1:0] LETTER_BASE = 6'd10;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PRE,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e                  phase;
    logic                    minus;
    logic [RADIX_WIDTH-1:0]  base;
    logic [VALUE_WIDTH-1:0]  acc;
    logic [COUNT_WIDTH-1:0]  cnt;
  } parse_state_t;

  localparam parse_state_t ST_CLEAR = '{
    phase: PH_SPACE,
    minus: 1'b0,
    base:  '0,
    acc:   '0,
    cnt:   '0
  };

endpackage

// ===== src/ascii_to_unsigned_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser_top
// Streaming parser that turns a character stream into unsigned integers.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tuser = start_new, tdata = ch
//  m_axis    out  tdata = value, consumed (from bit 0 up)
//  cfg       in   cfg_data_i = radix
//
//  One character is taken per cycle unless a terminating character waits on a
//  full result register; an input register feeds the step logic, which updates
//  the parse state and fills the result register. A result passes the input
//  register and then the result register after its terminating character is taken.
//  Reset clears the parse state and sets the radix to automatic detection.
//  A stalled result holds only an item that would produce another result.
// ----------------------------------------------------------------------------
module ascii_to_unsigned_parser_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [atup_pkg::CHAR_WIDTH-1:0]          s_axis_tdata,  // ch
  input  logic                                     s_axis_tuser,  // start_new
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [atup_pkg::OUT_TDATA_WIDTH-1:0]     m_axis_tdata,  // value, consumed
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [atup_pkg::RADIX_WIDTH-1:0]         cfg_data_i
);
  import atup_pkg::*;

  logic                    in_valid_q;
  logic                    in_start_q;
  logic [CHAR_WIDTH-1:0]   in_ch_q;
  parse_state_t            state_q;
  parse_state_t            state_d;
  logic [RADIX_WIDTH-1:0]  radix_q;
  logic                    out_valid_q;
  logic [VALUE_WIDTH-1:0]  out_value_q;
  logic [COUNT_WIDTH-1:0]  out_count_q;

  logic                    step_emit;
  logic [VALUE_WIDTH-1:0]  step_value;
  logic [COUNT_WIDTH-1:0]  step_count;
  logic                    out_free;
  logic                    advance;
  logic                    out_load;

  atup_step u_step (
    .cur_i      (state_q),
    .start_i    (in_start_q),
    .ch_i       (in_ch_q),
    .radix_i    (radix_q),
    .nxt_o      (state_d),
    .emit_o     (step_emit),
    .value_o    (step_value),
    .consumed_o (step_count)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!step_emit || out_free);
  assign out_load      = advance && step_emit;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_WIDTH'({out_count_q, out_value_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= ST_CLEAR;
      radix_q     <= RADIX_AUTO;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        radix_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_start_q <= s_axis_tuser;
      in_ch_q    <= s_axis_tdata;
    end
    if (out_load) begin
      out_value_q <= step_value;
      out_count_q <= step_count;
    end
  end

  a_result_ends_number : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q.phase == PH_DONE))
    else $error("parse state not finished after a result transfer");

  a_blocked_item_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && step_emit && out_valid_q && !m_axis_tready) |=> in_valid_q)
    else $error("character dropped while the result register was full");

  a_count_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_start_q) |=> (state_q.cnt >= $past(state_q.cnt)))
    else $error("consumed count decreased within one number");

endmodule

// ===== src/atup_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atup_step
// Next-state logic for one character: whitespace, sign, base prefix and
// digit accumulation, plus the result produced on the terminating character.
// ----------------------------------------------------------------------------
module atup_step (
  input  atup_pkg::parse_state_t               cur_i,
  input  logic                                 start_i,
  input  logic [atup_pkg::CHAR_WIDTH-1:0]      ch_i,
  input  logic [atup_pkg::RADIX_WIDTH-1:0]     radix_i,
  output atup_pkg::parse_state_t               nxt_o,
  output logic                                 emit_o,
  output logic [atup_pkg::VALUE_WIDTH-1:0]     value_o,
  output logic [atup_pkg::COUNT_WIDTH-1:0]     consumed_o
);
  import atup_pkg::*;

  logic                           is_space;
  logic                           dig_ok;
  logic [RADIX_WIDTH-1:0]         dig_val;
  logic [VALUE_WIDTH+RADIX_WIDTH-1:0] prod;
  parse_state_t                   st;
  logic                           hold;
  logic                           count;

  assign is_space = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));

  always_comb begin
    dig_ok  = 1'b1;
    dig_val = '0;
    if ((ch_i >= CH_ZERO) && (ch_i <= CH_NINE)) begin
      dig_val = RADIX_WIDTH'(ch_i - CH_ZERO);
    end else if ((ch_i >= CH_LC_A) && (ch_i <= CH_LC_Z)) begin
      dig_val = RADIX_WIDTH'(ch_i - CH_LC_A) + LETTER_BASE;
    end else if ((ch_i >= CH_UC_A) && (ch_i <= CH_UC_Z)) begin
      dig_val = RADIX_WIDTH'(ch_i - CH_UC_A) + LETTER_BASE;
    end else begin
      dig_ok = 1'b0;
    end
  end

  always_comb begin
    st     = start_i ? ST_CLEAR : cur_i;
    hold   = (st.phase == PH_DONE);
    count  = 1'b0;
    emit_o = 1'b0;
    prod   = '0;

    if (!hold && st.phase == PH_SPACE) begin
      if (is_space) begin
        count = 1'b1;
        hold  = 1'b1;
      end else begin
        st.phase = PH_PRE;
        if (ch_i == CH_MINUS || ch_i == CH_PLUS) begin
          st.minus = (ch_i == CH_MINUS);
          count    = 1'b1;
          hold     = 1'b1;
        end
      end
    end

    if (!hold && st.phase == PH_PRE) begin
      if (radix_i == RADIX_AUTO) begin
        if (ch_i == CH_ZERO) begin
          st.base  = BASE_OCT;
          st.phase = PH_ZERO;
          count    = 1'b1;
          hold     = 1'b1;
        end else begin
          st.base  = BASE_DEC;
          st.phase = PH_DIGITS;
        end
      end else if (radix_i == BASE_HEX) begin
        st.base = BASE_HEX;
        if (ch_i == CH_ZERO) begin
          st.phase = PH_ZERO;
          count    = 1'b1;
          hold     = 1'b1;
        end else begin
          st.phase = PH_DIGITS;
        end
      end else begin
        st.base  = radix_i;
        st.phase = PH_DIGITS;
      end
    end

    if (!hold && st.phase == PH_ZERO) begin
      st.phase = PH_DIGITS;
      if (ch_i == CH_LC_X) begin
        st.base = BASE_HEX;
        count   = 1'b1;
        hold    = 1'b1;
      end
    end

    if (!hold && st.phase == PH_DIGITS) begin
      if (dig_ok && (dig_val < st.base)) begin
        prod   = (VALUE_WIDTH + RADIX_WIDTH)'(st.acc) * (VALUE_WIDTH + RADIX_WIDTH)'(st.base);
        st.acc = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dig_val);
        count  = 1'b1;
      end else begin
        st.phase = PH_DONE;
        emit_o   = 1'b1;
      end
    end

    if (count && (st.cnt != {COUNT_WIDTH{1'b1}})) begin
      st.cnt = st.cnt + COUNT_WIDTH'(1);
    end

    nxt_o = st;
  end

  assign value_o    = st.minus ? (VALUE_WIDTH'(0) - st.acc) : st.acc;
  assign consumed_o = st.cnt;

endmodule
